// File: hdl/brbs_pkg.sv
package brbs_pkg;

	localparam int CFG_W = 9;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_POP   = 3'd1;
	localparam logic [2:0] MODE_PEEK  = 3'd2;
	localparam logic [2:0] MODE_SKIP  = 3'd3;
	localparam logic [2:0] MODE_FIND  = 3'd4;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic [7:0] offset;
		logic [8:0] skip_count;
	} brbs_in_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [7:0] stored_count;
		logic [8:0] free_space;
		logic       found;
		logic [7:0] found_position;
	} brbs_out_t;

endpackage

// File: hdl/byte_ring_buffer_with_search.sv
// states from accept to result: unused modes S_DONE only; write S_WRITE; pop S_POP, S_RDATA;
// skip S_RED1-3; peek S_RED1-3, S_PEEK, S_RDATA; find S_RED1-3, then S_FIND over the stored bytes
// one word is handled at a time; the next word is accepted after the result is registered, while
// cfg_we is low; find reads one byte store entry per cycle, also only while cfg_we is low
// reset: both pointers zero, length in use 256 (or the depth if smaller), no result pending;
// byte store contents are undefined until written, and a length write zeroes both pointers
module byte_ring_buffer_with_search #(
	parameter int DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  brbs_pkg::brbs_in_t     in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output brbs_pkg::brbs_out_t    out_data,
	input  logic                   cfg_we,
	input  logic [brbs_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int MAXLEN  = (DEPTH < 511) ? DEPTH : 511;
	localparam int PTR_W   = $clog2(MAXLEN);
	localparam int LEN_W   = $clog2(MAXLEN + 1);
	localparam int RW      = LEN_W + 9;
	localparam int RST_LEN = (MAXLEN < 256) ? MAXLEN : 256;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WRITE = 4'd1;
	localparam logic [3:0] S_POP   = 4'd2;
	localparam logic [3:0] S_RDATA = 4'd3;
	localparam logic [3:0] S_RED1  = 4'd4;
	localparam logic [3:0] S_RED2  = 4'd5;
	localparam logic [3:0] S_RED3  = 4'd6;
	localparam logic [3:0] S_PEEK  = 4'd7;
	localparam logic [3:0] S_FIND  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]          state_q;
	logic [LEN_W-1:0]    len_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    rp_q;
	brbs_pkg::brbs_in_t  item_q;
	logic [8:0]          x_q;
	logic [PTR_W-1:0]    pos_q;
	logic [PTR_W-1:0]    scan_pos_q;
	logic [LEN_W-1:0]    scan_left_q;
	logic [LEN_W-1:0]    scan_n_q;
	logic                chk_v_s1;
	logic [LEN_W-1:0]    chk_n_s1;
	logic [7:0]          rb_q;
	logic                found_q;
	logic [LEN_W-1:0]    fpos_q;
	logic                out_valid_q;
	brbs_pkg::brbs_out_t out_q;

	logic                ram_we;
	logic [PTR_W-1:0]    ram_addr;
	logic [7:0]          ram_rdata;

	logic [RW-1:0]       red_hi;
	logic [RW-1:0]       red_lo;
	logic [LEN_W:0]      pos_sum;
	logic [PTR_W-1:0]    pos_wrap;
	logic [LEN_W-1:0]    cnt;
	logic [PTR_W-1:0]    wp_inc;
	logic [PTR_W-1:0]    rp_inc;
	logic [PTR_W-1:0]    scan_inc;
	logic                match;
	logic                out_free;
	logic                out_load;

	brbs_ram #(
		.WIDTH(8),
		.DEPTH(MAXLEN)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (item_q.data_byte),
		.rdata (ram_rdata)
	);

	// remainder by the length, high and low halves of the shift-subtract
	always_comb begin
		red_hi = RW'(x_q);
		for (int k = 8; k >= 5; k--) begin
			if (red_hi >= (RW'(len_q) << k)) begin
				red_hi = red_hi - (RW'(len_q) << k);
			end
		end
		red_lo = RW'(x_q);
		for (int k = 4; k >= 0; k--) begin
			if (red_lo >= (RW'(len_q) << k)) begin
				red_lo = red_lo - (RW'(len_q) << k);
			end
		end
	end

	always_comb begin
		pos_sum = (LEN_W+1)'(rp_q) + (LEN_W+1)'(x_q);
		if (pos_sum >= (LEN_W+1)'(len_q)) begin
			pos_wrap = PTR_W'(pos_sum - (LEN_W+1)'(len_q));
		end else begin
			pos_wrap = PTR_W'(pos_sum);
		end
		if (wp_q >= rp_q) begin
			cnt = LEN_W'(wp_q) - LEN_W'(rp_q);
		end else begin
			cnt = LEN_W'(wp_q) + len_q - LEN_W'(rp_q);
		end
		wp_inc   = (LEN_W'(wp_q) + 1'b1 == len_q) ? '0 : wp_q + 1'b1;
		rp_inc   = (LEN_W'(rp_q) + 1'b1 == len_q) ? '0 : rp_q + 1'b1;
		scan_inc = (LEN_W'(scan_pos_q) + 1'b1 == len_q) ? '0 : scan_pos_q + 1'b1;
		match    = chk_v_s1 && (ram_rdata == item_q.data_byte);
		out_free = !out_valid_q || out_ready;
		out_load = (state_q == S_DONE) && out_free && !cfg_we;
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = wp_q;
		case (state_q)
			S_WRITE: begin
				ram_we = 1'b1;
			end
			S_POP: begin
				ram_addr = rp_q;
			end
			S_PEEK: begin
				ram_addr = pos_q;
			end
			S_FIND: begin
				ram_addr = scan_pos_q;
			end
			default: begin
				ram_addr = wp_q;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE) && !cfg_we;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= LEN_W'(RST_LEN);
			wp_q        <= '0;
			rp_q        <= '0;
			chk_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_wdata == '0) begin
					len_q <= LEN_W'(1);
				end else if (32'(cfg_wdata) > MAXLEN) begin
					len_q <= LEN_W'(MAXLEN);
				end else begin
					len_q <= LEN_W'(cfg_wdata);
				end
				wp_q <= '0;
				rp_q <= '0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							item_q  <= in_data;
							rb_q    <= '0;
							found_q <= 1'b0;
							fpos_q  <= '0;
							x_q     <= (in_data.mode == brbs_pkg::MODE_SKIP) ?
								in_data.skip_count : {1'b0, in_data.offset};
							if (in_data.mode == brbs_pkg::MODE_WRITE) begin
								state_q <= S_WRITE;
							end else if (in_data.mode == brbs_pkg::MODE_POP) begin
								state_q <= S_POP;
							end else if (in_data.mode inside {brbs_pkg::MODE_PEEK,
								brbs_pkg::MODE_SKIP, brbs_pkg::MODE_FIND}) begin
								state_q <= S_RED1;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
					S_WRITE: begin
						wp_q    <= wp_inc;
						state_q <= S_DONE;
					end
					S_POP: begin
						rp_q    <= rp_inc;
						state_q <= S_RDATA;
					end
					S_RDATA: begin
						rb_q    <= ram_rdata;
						state_q <= S_DONE;
					end
					S_RED1: begin
						x_q     <= 9'(red_hi);
						state_q <= S_RED2;
					end
					S_RED2: begin
						x_q     <= 9'(red_lo);
						state_q <= S_RED3;
					end
					S_RED3: begin
						case (item_q.mode)
							brbs_pkg::MODE_SKIP: begin
								rp_q    <= pos_wrap;
								state_q <= S_DONE;
							end
							brbs_pkg::MODE_PEEK: begin
								pos_q   <= pos_wrap;
								state_q <= S_PEEK;
							end
							default: begin
								scan_pos_q  <= pos_wrap;
								scan_n_q    <= '0;
								scan_left_q <= (LEN_W'(x_q) < cnt) ? cnt - LEN_W'(x_q) : '0;
								state_q     <= S_FIND;
							end
						endcase
					end
					S_PEEK: begin
						state_q <= S_RDATA;
					end
					S_FIND: begin
						if (match) begin
							found_q  <= 1'b1;
							fpos_q   <= chk_n_s1;
							chk_v_s1 <= 1'b0;
							state_q  <= S_DONE;
						end else if (scan_left_q == '0) begin
							chk_v_s1 <= 1'b0;
							state_q  <= S_DONE;
						end else begin
							chk_v_s1    <= 1'b1;
							chk_n_s1    <= scan_n_q;
							scan_n_q    <= scan_n_q + 1'b1;
							scan_left_q <= scan_left_q - 1'b1;
							scan_pos_q  <= scan_inc;
						end
					end
					S_DONE: begin
						if (out_load) begin
							out_valid_q          <= 1'b1;
							out_q.read_byte      <= rb_q;
							out_q.stored_count   <= 8'(cnt);
							out_q.free_space     <= 9'(len_q - cnt);
							out_q.found          <= found_q;
							out_q.found_position <= 8'(fpos_q);
							state_q              <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	ap_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(LEN_W'(wp_q) < len_q) && (LEN_W'(rp_q) < len_q))
		else $error("pointer beyond length in use");

	ap_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) && (32'(len_q) <= MAXLEN))
		else $error("length in use out of range");

	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !cfg_we) |=> (state_q != S_IDLE))
		else $error("word accepted but no work started");

	ap_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (scan_left_q < len_q))
		else $error("scan longer than stored bytes");

	ap_found_mode: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (item_q.mode == brbs_pkg::MODE_FIND))
		else $error("found flag outside find");

endmodule

// File: hdl/brbs_ram.sv
module brbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
